>>> src/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tms_pkg.sv
// Types and constants for the tempo melody sequencer.
// No dependencies; used by tms_divider and tempo_melody_sequencer_unit.
package tms_pkg;

    localparam int DEF_MAX_NOTES = 256;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 8;
    localparam int PITCH_W   = 16;
    localparam int UNITS_W   = 8;
    localparam int EVENT_W   = 2;
    localparam int NOTE_W    = 8;
    localparam int TEMPO_W   = 10;
    localparam int MLEN_W    = 9;
    localparam int CFG_W     = 10;
    localparam int UNIT_MS_W = 14;
    localparam int TICKS_W   = 22;

    // Tempo division: 60000 ms per minute, four units per beat
    localparam int QUO_W          = 16;
    localparam int QCNT_W         = 4;
    localparam int BEAT_SHIFT     = 2;
    localparam logic [QUO_W-1:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 10'd120;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_PLAY = 2'd2,
        KIND_STOP = 2'd3
    } t_kind;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 2'd0,
        EV_START   = 2'd1,
        EV_SILENCE = 2'd2
    } t_event;

    typedef enum logic {
        CFG_TEMPO  = 1'b0,
        CFG_LENGTH = 1'b1
    } t_cfg_idx;

endpackage

>>> src/tms_divider.sv
// Radix-2 restoring divider: 60000 / divisor, one quotient bit per cycle.
// Depends on tms_pkg.
module tms_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tms_pkg::TEMPO_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [tms_pkg::QUO_W-1:0]   o_quotient
);
    import tms_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [QCNT_W-1:0]   r_cnt;
    logic [TEMPO_W-1:0]  r_div;
    logic [TEMPO_W-1:0]  r_rem;
    logic [QUO_W-1:0]    r_quo;

    logic [TEMPO_W:0]    trial;
    logic                q_bit;
    logic [TEMPO_W:0]    n_rem;

    // Dividend bits shift out of the top of r_quo as quotient bits shift in
    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        q_bit = (trial >= {1'b0, r_div});
        n_rem = q_bit ? (trial - {1'b0, r_div}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= MS_PER_MINUTE;
            end else if (r_busy) begin
                r_rem <= n_rem[TEMPO_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {QCNT_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> src/tempo_melody_sequencer_unit.sv
// Tempo melody sequencer top level: command decode, note table memory, playback.
// Depends on tms_pkg, tms_divider and assert_macros.svh.
//
// Commands are taken when i_start is high and o_busy is low; each command
// gives exactly one result, shown for one cycle with o_valid, which the
// receiver must take. Load, stop and a tick that does not advance answer
// the cycle after accept. A tick that advances to the next note passes
// through the note table read, then the duration multiply. Play runs the
// 16-step tempo divider, then the note table read and multiply, before its
// result. o_busy is high while a command is in progress. The note table
// has no reset: entries must be loaded before they are played.
module tempo_melody_sequencer_unit #(
    parameter int MAX_NOTES = tms_pkg::DEF_MAX_NOTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [tms_pkg::KIND_W-1:0]  i_kind,
    input  logic [tms_pkg::SLOT_W-1:0]  i_note_slot,
    input  logic [tms_pkg::PITCH_W-1:0] i_note_pitch,
    input  logic [tms_pkg::UNITS_W-1:0] i_note_length_units,
    // result channel
    output logic                        o_valid,
    output logic [tms_pkg::EVENT_W-1:0] o_tone_event,
    output logic [tms_pkg::PITCH_W-1:0] o_tone_pitch,
    output logic                        o_busy_playing,
    output logic [tms_pkg::NOTE_W-1:0]  o_current_note,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [tms_pkg::CFG_W-1:0]   i_cfg_data
);
    import tms_pkg::*;
    `include "assert_macros.svh"

    localparam int AW     = $clog2(MAX_NOTES);
    localparam int PW     = $clog2(MAX_NOTES + 1);
    localparam int ENTRY_W = PITCH_W + UNITS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_START
    } t_state;

    t_state               r_state;

    // configuration
    logic [TEMPO_W-1:0]   r_tempo;
    logic [MLEN_W-1:0]    r_mel_len;

    // playback state
    logic [PW-1:0]        r_position;
    logic [PW-1:0]        r_play_len;
    logic [TICKS_W-1:0]   r_ticks_left;
    logic [UNIT_MS_W-1:0] r_unit_ms;
    logic                 r_active;

    // result registers
    logic                 r_valid;
    t_event               r_event;
    logic [PITCH_W-1:0]   r_pitch;
    logic                 r_playing;
    logic [NOTE_W-1:0]    r_note;

    // note table
    logic [ENTRY_W-1:0]   r_mem [MAX_NOTES];
    logic [ENTRY_W-1:0]   r_rd_data;

    logic                 accept;
    t_kind                kind;
    logic [31:0]          slot_ext;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [PW-1:0]        n_position;
    logic [PW-1:0]        n_play_len;
    logic [TEMPO_W-1:0]   bpm;
    logic                 div_start;
    logic                 div_done;
    logic [QUO_W-1:0]     div_quo;
    logic [TICKS_W-1:0]   note_ticks;
    logic [31:0]          pos_ext;
    logic [NOTE_W-1:0]    cur_note;

    always_comb begin
        accept     = i_start && (r_state == S_IDLE);
        kind       = t_kind'(i_kind);
        slot_ext   = 32'(i_note_slot);
        wr_addr    = slot_ext[AW-1:0];
        mem_we     = accept && (kind == KIND_LOAD) && (slot_ext < 32'(MAX_NOTES));
        n_position = r_position + 1'b1;
        n_play_len = (32'(r_mel_len) > 32'(MAX_NOTES)) ? PW'(MAX_NOTES) : PW'(r_mel_len);
        bpm        = (r_tempo == '0) ? TEMPO_W'(1) : r_tempo;
        div_start  = accept && (kind == KIND_PLAY) && (r_mel_len != '0);
        note_ticks = {{(TICKS_W-UNITS_W){1'b0}}, r_rd_data[UNITS_W-1:0]}
                   * {{(TICKS_W-UNIT_MS_W){1'b0}}, r_unit_ms};
        pos_ext    = 32'(r_position);
        cur_note   = r_active ? pos_ext[NOTE_W-1:0] : '0;
    end

    tms_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (bpm),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Note table: {pitch, units}; read address follows the play position
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= {i_note_pitch, i_note_length_units};
        end
        r_rd_data <= r_mem[r_position[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo <= TEMPO_RESET;
            r_mel_len <= '0;
        end else if (i_cfg_we) begin
            if (t_cfg_idx'(i_cfg_idx) == CFG_TEMPO) begin
                r_tempo <= i_cfg_data[TEMPO_W-1:0];
            end else begin
                r_mel_len <= i_cfg_data[MLEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_position   <= '0;
            r_play_len   <= '0;
            r_ticks_left <= '0;
            r_unit_ms    <= '0;
            r_active     <= 1'b0;
            r_valid      <= 1'b0;
            r_event      <= EV_NONE;
            r_pitch      <= '0;
            r_playing    <= 1'b0;
            r_note       <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_event   <= EV_NONE;
                        r_pitch   <= '0;
                        r_playing <= r_active;
                        r_note    <= cur_note;
                        r_valid   <= 1'b1;
                        unique case (kind)
                            KIND_LOAD: begin
                            end
                            KIND_STOP: begin
                                r_active  <= 1'b0;
                                r_event   <= EV_SILENCE;
                                r_playing <= 1'b0;
                                r_note    <= '0;
                            end
                            KIND_PLAY: begin
                                if (r_mel_len != '0) begin
                                    r_valid    <= 1'b0;
                                    r_play_len <= n_play_len;
                                    r_position <= '0;
                                    r_state    <= S_DIV;
                                end
                            end
                            KIND_TICK: begin
                                if (r_active) begin
                                    if (r_ticks_left != '0) begin
                                        r_ticks_left <= r_ticks_left - 1'b1;
                                    end else if (n_position < r_play_len) begin
                                        r_valid    <= 1'b0;
                                        r_position <= n_position;
                                        r_state    <= S_READ;
                                    end else begin
                                        // ran off the end of the melody
                                        r_position <= n_position;
                                        r_active   <= 1'b0;
                                        r_event    <= EV_SILENCE;
                                        r_playing  <= 1'b0;
                                        r_note     <= '0;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_unit_ms <= div_quo[BEAT_SHIFT +: UNIT_MS_W];
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_ticks_left <= note_ticks;
                    r_active     <= 1'b1;
                    r_valid      <= 1'b1;
                    r_event      <= EV_START;
                    r_pitch      <= r_rd_data[ENTRY_W-1:UNITS_W];
                    r_playing    <= 1'b1;
                    r_note       <= pos_ext[NOTE_W-1:0];
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_tone_event   = r_event;
    assign o_tone_pitch   = r_pitch;
    assign o_busy_playing = r_playing;
    assign o_current_note = r_note;

    `ASSERT_NEXT(a_quick_result, i_clk, i_rst_n,
        i_start && !o_busy && ((i_kind == KIND_LOAD) || (i_kind == KIND_STOP)),
        o_valid && !o_busy,
        "load or stop transaction did not answer in the next cycle")
    `ASSERT_SAME(a_start_plays, i_clk, i_rst_n,
        o_valid && (o_tone_event == EV_START), o_busy_playing,
        "tone start reported while not playing")
    `ASSERT_SAME(a_idle_note, i_clk, i_rst_n,
        o_valid && !o_busy_playing, o_current_note == '0,
        "current note nonzero while idle")
    `ASSERT_SAME(a_pos_range, i_clk, i_rst_n,
        r_active, r_position < r_play_len,
        "play position beyond melody length while active")

endmodule
